FILE: sv/cfrc_pkg.sv
// ----------------------------------------------------------------------------
// cfrc_pkg: shared definitions for the column first-run centroid block
// Widths, phase codes, the column store entry and controller/datapath links.
// ----------------------------------------------------------------------------
package cfrc_pkg;

    localparam int MAX_COLS  = 2048;
    localparam int MAX_ROWS  = 2048;
    localparam int FRAC_BITS = 8;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DIM_W  = 12;
    localparam int SUM_W  = 22;
    localparam int LEN_W  = 12;
    localparam int POS_W  = 19;
    localparam int DIVD_W = SUM_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W);
    localparam int IDX_W  = 1;

    localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(640);
    localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] COLS_MAX   = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] ROWS_MAX   = DIM_W'(MAX_ROWS);

    // register indexes
    localparam logic [IDX_W-1:0] REG_COLS = 1'b0;
    localparam logic [IDX_W-1:0] REG_ROWS = 1'b1;

    // column phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    typedef struct packed {
        logic [1:0]       phase;
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef struct packed {
        logic load;
        logic calc;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic found;
        logic div_last;
    } t_sts;

endpackage

FILE: sv/cfrc_ctrl.sv
// ----------------------------------------------------------------------------
// cfrc_ctrl: sequencing controller
// Steps each pixel through store read and update, then through optional division and output when a result is due.
// ----------------------------------------------------------------------------
module cfrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  cfrc_pkg::t_sts  i_sts,
    output cfrc_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_CALC;
            S_CALC: begin
                if (i_sts.emit && i_sts.found) n_state = S_DIV;
                else if (i_sts.emit)           n_state = S_OUT;
                else                           n_state = S_IDLE;
            end
            S_DIV:  if (i_sts.div_last) n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // commands to the datapath
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_cmd.load    = (r_state == S_IDLE) && i_valid;
    assign o_cmd.calc    = (r_state == S_CALC);
    assign o_cmd.div_step = (r_state == S_DIV);

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready) else $error("not free after transfer");
    a_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.calc) else $error("update did not follow load");

endmodule

FILE: sv/cfrc_dp.sv
// ----------------------------------------------------------------------------
// cfrc_dp: datapath
// Position tracking, column store, run update and serial restoring divider.
// ----------------------------------------------------------------------------
module cfrc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cfrc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [cfrc_pkg::DIM_W-1:0]   i_cfg_data,
    input  logic [7:0]                   i_pixel,
    input  logic                         i_frame_start,
    input  cfrc_pkg::t_cmd               i_cmd,
    output cfrc_pkg::t_sts               o_sts,
    output logic [cfrc_pkg::COL_W-1:0]   o_column,
    output logic [cfrc_pkg::POS_W-1:0]   o_position,
    output logic                         o_found
);

    localparam int DW = cfrc_pkg::DIM_W;

    logic [DW-1:0] r_cols_cfg, r_rows_cfg;
    logic [DW-1:0] cols, rows;
    logic [cfrc_pkg::COL_W-1:0] r_col_pos, r_col;
    logic [cfrc_pkg::ROW_W-1:0] r_row_pos, r_row;
    logic r_set;
    cfrc_pkg::t_entry mem [cfrc_pkg::MAX_COLS];
    cfrc_pkg::t_entry r_rd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= cfrc_pkg::COLS_RESET;
            r_rows_cfg <= cfrc_pkg::ROWS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cfrc_pkg::REG_COLS) r_cols_cfg <= i_cfg_data;
            if (i_cfg_idx == cfrc_pkg::REG_ROWS) r_rows_cfg <= i_cfg_data;
        end
    end

    // clamp dimensions to the supported range
    always_comb begin
        cols = (r_cols_cfg == '0) ? DW'(1) :
               (r_cols_cfg > cfrc_pkg::COLS_MAX) ? cfrc_pkg::COLS_MAX : r_cols_cfg;
        rows = (r_rows_cfg == '0) ? DW'(1) :
               (r_rows_cfg > cfrc_pkg::ROWS_MAX) ? cfrc_pkg::ROWS_MAX : r_rows_cfg;
    end

    // position of the incoming pixel, with wrap
    logic [DW-1:0] c_col, c_row;
    always_comb begin
        c_col = i_frame_start ? '0 : DW'(r_col_pos);
        c_row = i_frame_start ? '0 : DW'(r_row_pos);
        if (c_col >= cols) begin
            c_col = '0;
            c_row = c_row + DW'(1);
        end
        if (c_row >= rows) c_row = '0;
    end

    // latch pixel and read the column store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= c_col[cfrc_pkg::COL_W-1:0];
            r_row <= c_row[cfrc_pkg::ROW_W-1:0];
            r_set <= (i_pixel != 8'd0);
            r_rd  <= mem[c_col[cfrc_pkg::COL_W-1:0]];
        end
    end

    // run update
    cfrc_pkg::t_entry cur, upd;
    logic emit, found, active;
    always_comb begin
        cur = r_rd;
        if (r_row == '0) cur = '0;
        upd    = cur;
        emit   = 1'b0;
        found  = 1'b0;
        active = (cur.phase == cfrc_pkg::PH_IDLE) || (cur.phase == cfrc_pkg::PH_RUN);
        if (active && r_set) begin
            upd.sum   = cur.sum + cfrc_pkg::SUM_W'(r_row);
            upd.len   = cur.len + cfrc_pkg::LEN_W'(1);
            upd.phase = cfrc_pkg::PH_RUN;
        end else if (active && cur.phase == cfrc_pkg::PH_RUN) begin
            emit      = 1'b1;
            found     = 1'b1;
            upd.phase = cfrc_pkg::PH_DONE;
        end
        if (!emit && (DW'(r_row) == rows - DW'(1)) &&
            (upd.phase == cfrc_pkg::PH_IDLE || upd.phase == cfrc_pkg::PH_RUN)) begin
            emit      = 1'b1;
            found     = (upd.phase == cfrc_pkg::PH_RUN);
            upd.phase = cfrc_pkg::PH_DONE;
        end
    end

    // write back the column entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) mem[r_col] <= upd;
    end

    // advance raster position
    logic [DW-1:0] nx_col, nx_row;
    always_comb begin
        nx_col = DW'(r_col) + DW'(1);
        nx_row = DW'(r_row);
        if (nx_col >= cols) begin
            nx_col = '0;
            nx_row = DW'(r_row) + DW'(1);
            if (nx_row >= rows) nx_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (i_cmd.calc) begin
            r_col_pos <= nx_col[cfrc_pkg::COL_W-1:0];
            r_row_pos <= nx_row[cfrc_pkg::ROW_W-1:0];
        end
    end

    // serial restoring divider: one quotient bit a cycle
    logic [cfrc_pkg::DIVD_W-1:0] r_div;
    logic [cfrc_pkg::LEN_W-1:0]  r_rem, r_den;
    logic [cfrc_pkg::CNT_W-1:0]  r_cnt;
    logic [cfrc_pkg::LEN_W:0]    rem_sh;
    logic                        ge;
    logic [cfrc_pkg::LEN_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_div[cfrc_pkg::DIVD_W-1]};
        ge      = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_div <= {upd.sum, cfrc_pkg::FRAC_BITS'(0)};
            r_rem <= '0;
            r_den <= upd.len;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= {r_div[cfrc_pkg::DIVD_W-2:0], ge};
            r_rem <= ge ? rem_sub[cfrc_pkg::LEN_W-1:0] : rem_sh[cfrc_pkg::LEN_W-1:0];
            r_cnt <= r_cnt + cfrc_pkg::CNT_W'(1);
        end
    end

    assign o_sts.emit     = emit;
    assign o_sts.found    = found;
    assign o_sts.div_last = (r_cnt == cfrc_pkg::CNT_W'(cfrc_pkg::DIVD_W - 1));

    // hold the result for the output transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc && emit) begin
            o_column   <= r_col;
            o_found    <= found;
            o_position <= '0;
        end else if (i_cmd.div_step && o_sts.div_last) begin
            o_position <= (r_den == '0) ? '0 :
                          {r_div[cfrc_pkg::POS_W-2:0], ge};
        end
    end

endmodule

FILE: sv/column_first_run_centroid_top.sv
// ----------------------------------------------------------------------------
// column_first_run_centroid_top: per-column first-run centroid
// Reports the mean row of the first vertical run of set pixels in each column.
// ----------------------------------------------------------------------------
// Pixels are taken one at a time in raster order. A pixel that causes no
// result goes through accept with column store read, then update and
// write-back. A pixel that closes a run with a result goes through accept,
// update, division and output, plus the wait for the output transfer: the
// centroid (row sum << 8) / length is formed by a serial divider giving one
// quotient bit per cycle. A column with no run reports through accept, update
// and output with no division, plus the output wait. The column store is a
// single 2048-entry memory read once and written once per pixel.
module column_first_run_centroid_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cfrc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [cfrc_pkg::DIM_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_pixel,
    input  logic                        i_frame_start,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cfrc_pkg::COL_W-1:0]  o_column,
    output logic [cfrc_pkg::POS_W-1:0]  o_position,
    output logic                        o_found
);

    cfrc_pkg::t_cmd cmd;
    cfrc_pkg::t_sts sts;

    cfrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cfrc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_column      (o_column),
        .o_position    (o_position),
        .o_found       (o_found)
    );

    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_position == '0))
        else $error("position set without a run");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_position) && $stable(o_column))
        else $error("result changed while waiting");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> !o_valid)
        else $error("result repeated");

endmodule

FILE: sim/column_first_run_centroid_top_tb.sv
// ----------------------------------------------------------------------------
// column_first_run_centroid_top_tb: self-checking bench for the centroid block
// Drives raster pixels through the valid/ready input, models each column's
// first-run centroid in step, and checks every output transfer in order.
// ----------------------------------------------------------------------------
module column_first_run_centroid_top_tb;

    localparam int LIMIT_CYCLES   = 2000000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RX_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [cfrc_pkg::COL_W-1:0] column;
        logic [cfrc_pkg::POS_W-1:0] position;
        logic                       found;
    } t_centroid;

    typedef struct {
        logic [7:0]                 pixel;
        logic                       fs;
        bit                         typed;
        bit                         has_res;
        logic [cfrc_pkg::COL_W-1:0] column;
        logic [cfrc_pkg::POS_W-1:0] position;
        logic                       found;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [cfrc_pkg::IDX_W-1:0] i_cfg_idx;
    logic [cfrc_pkg::DIM_W-1:0] i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic [7:0]                 i_pixel;
    logic                       i_frame_start;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [cfrc_pkg::COL_W-1:0] o_column;
    logic [cfrc_pkg::POS_W-1:0] o_position;
    logic                       o_found;

    // model copy of registers and column store
    logic [cfrc_pkg::DIM_W-1:0] m_cols, m_rows;
    int unsigned                m_row, m_col;
    logic [1:0]                 m_phase [cfrc_pkg::MAX_COLS];
    logic [cfrc_pkg::SUM_W-1:0] m_sum   [cfrc_pkg::MAX_COLS];
    logic [cfrc_pkg::LEN_W-1:0] m_len   [cfrc_pkg::MAX_COLS];
    bit                         m_written [cfrc_pkg::MAX_COLS];

    t_centroid            centroid_q [$];
    int                   err_cnt = 0;
    int                   cycle_cnt = 0;
    int                   tx_idle_pct = 0;
    int                   rx_stall_pct = 0;
    int                   rx_hold_left = 0;
    bit                   rx_hold_go = 1'b0;
    bit                   rx_hold_taken = 1'b0;

    column_first_run_centroid_top u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0d] mismatch %s: got %0d, want %0d", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    function automatic int unsigned eff_dim(input logic [cfrc_pkg::DIM_W-1:0] v,
                                            input int unsigned hi);
        if (v == '0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // where the next pixel lands, wraps applied
    function automatic void land(input logic fs, output int unsigned row,
                                 output int unsigned col);
        int unsigned cols, rows;
        cols = eff_dim(m_cols, cfrc_pkg::MAX_COLS);
        rows = eff_dim(m_rows, cfrc_pkg::MAX_ROWS);
        row = fs ? 0 : m_row;
        col = fs ? 0 : m_col;
        if (col >= cols) begin
            col = 0;
            row++;
        end
        if (row >= rows) row = 0;
    endfunction

    function automatic t_centroid make_centroid(input int unsigned col, input bit hit);
        t_centroid r;
        logic [cfrc_pkg::DIVD_W-1:0] num;
        r.column = col[cfrc_pkg::COL_W-1:0];
        r.found = hit;
        r.position = '0;
        if (hit && m_len[col] != '0) begin
            num = {m_sum[col], {cfrc_pkg::FRAC_BITS{1'b0}}};
            r.position = cfrc_pkg::POS_W'(num / m_len[col]);
        end
        return r;
    endfunction

    // advance the column model by one pixel; return the centroid if one is due
    function automatic bit step_centroid(input logic [7:0] pix, input logic fs,
                                         output t_centroid res);
        int unsigned cols, rows, row, col;
        logic [1:0] ph;
        bit emitted;
        cols = eff_dim(m_cols, cfrc_pkg::MAX_COLS);
        rows = eff_dim(m_rows, cfrc_pkg::MAX_ROWS);
        land(fs, row, col);
        emitted = 0;
        res = '0;
        if (row == 0) begin
            m_phase[col] = cfrc_pkg::PH_IDLE;
            m_sum[col] = '0;
            m_len[col] = '0;
            m_written[col] = 1;
        end
        ph = m_phase[col];
        if (ph == cfrc_pkg::PH_IDLE || ph == cfrc_pkg::PH_RUN) begin
            if (pix != 8'd0) begin
                m_sum[col] = m_sum[col] + cfrc_pkg::SUM_W'(row);
                m_len[col] = m_len[col] + cfrc_pkg::LEN_W'(1);
                ph = cfrc_pkg::PH_RUN;
            end else if (ph == cfrc_pkg::PH_RUN) begin
                res = make_centroid(col, 1);
                emitted = 1;
                ph = cfrc_pkg::PH_DONE;
            end
        end
        if (!emitted && row == rows - 1 &&
            (ph == cfrc_pkg::PH_IDLE || ph == cfrc_pkg::PH_RUN)) begin
            res = make_centroid(col, ph == cfrc_pkg::PH_RUN);
            emitted = 1;
            ph = cfrc_pkg::PH_DONE;
        end
        m_phase[col] = ph;
        m_col = col + 1;
        m_row = row;
        if (m_col >= cols) begin
            m_col = 0;
            m_row = row + 1;
            if (m_row >= rows) m_row = 0;
        end
        return emitted;
    endfunction

    // offer one pixel, hold it until the transfer, then queue what it causes
    task automatic send_pixel(input logic [7:0] pix, input logic fs_in,
                              input bit typed, input t_centroid typed_res,
                              input bit typed_has);
        int unsigned row, col;
        logic fs;
        t_centroid res;
        bit has;
        fs = fs_in;
        land(fs, row, col);
        if (row != 0 && !m_written[col]) fs = 1'b1;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        has = step_centroid(pix, fs, res);
        if (typed) begin
            has = typed_has;
            res = typed_res;
        end
        if (has) centroid_q.push_back(res);
    endtask

    task automatic send_random(input logic fs, input int set_pct);
        logic [7:0] pix;
        pix = ($urandom_range(99) < set_pct) ? 8'($urandom_range(1, 255)) : 8'd0;
        send_pixel(pix, fs, 0, '0, 0);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (centroid_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [cfrc_pkg::IDX_W-1:0] idx,
                             input logic [cfrc_pkg::DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cfrc_pkg::REG_COLS) m_cols = val;
        else m_rows = val;
    endtask

    // receiver: one long hold-off when asked, otherwise random stalls
    always @(negedge i_clk) begin
        if (rx_hold_go && !rx_hold_taken) begin
            rx_hold_taken <= 1'b1;
            rx_hold_left <= RX_HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            i_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // check each output transfer against the oldest expected centroid
    always @(posedge i_clk) begin
        t_centroid want;
        if (i_rst_n && o_valid && i_ready) begin
            if (centroid_q.size() == 0) begin
                report_mismatch("unexpected result, column", o_column, -1);
            end else begin
                want = centroid_q.pop_front();
                if (o_column !== want.column)
                    report_mismatch("column", o_column, want.column);
                if (o_position !== want.position)
                    report_mismatch("position", o_position, want.position);
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("column_first_run_centroid_top_tb: done, errors");
            $finish;
        end
    end

    t_row directed [18] = '{
        // 2 x 2 frame, run through both rows of column 0
        '{8'hFF, 1'b1, 1, 0, 0, 0, 0},
        '{8'h00, 1'b0, 1, 0, 0, 0, 0},
        '{8'h01, 1'b0, 1, 1, 0, 19'd128, 1},
        '{8'h00, 1'b0, 1, 1, 1, 19'd0, 0},
        // next frame: run ends early in column 0, full run in column 1
        '{8'h80, 1'b0, 1, 0, 0, 0, 0},
        '{8'hFF, 1'b0, 1, 0, 0, 0, 0},
        '{8'h00, 1'b0, 1, 1, 0, 19'd0, 1},
        '{8'hFF, 1'b0, 1, 1, 1, 19'd128, 1},
        // restart mid-frame, then later runs that must be ignored
        '{8'hFF, 1'b1, 0, 0, 0, 0, 0},
        '{8'h00, 1'b1, 0, 0, 0, 0, 0},
        '{8'h7F, 1'b0, 0, 0, 0, 0, 0},
        '{8'h02, 1'b0, 0, 0, 0, 0, 0},
        '{8'h55, 1'b0, 0, 0, 0, 0, 0},
        '{8'hAA, 1'b0, 0, 0, 0, 0, 0},
        '{8'h00, 1'b0, 0, 0, 0, 0, 0},
        '{8'h04, 1'b0, 0, 0, 0, 0, 0},
        '{8'h08, 1'b0, 0, 0, 0, 0, 0},
        '{8'h10, 1'b0, 0, 0, 0, 0, 0}
    };

    initial begin
        int cols_sel, rows_sel, n_items;
        t_centroid tr;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = cfrc_pkg::REG_COLS;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel = '0;
        i_frame_start = 1'b0;
        m_cols = cfrc_pkg::COLS_RESET;
        m_rows = cfrc_pkg::ROWS_RESET;
        m_row = 0;
        m_col = 0;
        foreach (m_written[k]) m_written[k] = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small frame with known centroids
        write_reg(cfrc_pkg::REG_COLS, 12'd2);
        write_reg(cfrc_pkg::REG_ROWS, 12'd2);
        foreach (directed[k]) begin
            tr.column = directed[k].column;
            tr.position = directed[k].position;
            tr.found = directed[k].found;
            send_pixel(directed[k].pixel, directed[k].fs, directed[k].typed, tr,
                       directed[k].has_res);
        end
        settle();

        // single-row frame and zero registers acting as one
        write_reg(cfrc_pkg::REG_ROWS, 12'd1);
        write_reg(cfrc_pkg::REG_COLS, 12'd3);
        repeat (6) send_random(1'b0, 50);
        settle();
        write_reg(cfrc_pkg::REG_COLS, 12'd0);
        write_reg(cfrc_pkg::REG_ROWS, 12'd0);
        repeat (4) send_random(1'b0, 50);
        settle();

        // random phases: small images (one phase with 2048 rows), mostly whole frames
        for (int ph = 0; ph < 8; ph++) begin
            tx_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 34 : 50) : 0;
            rx_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 34 : 50) : 0;
            cols_sel = $urandom_range(1, 9);
            rows_sel = $urandom_range(1, 9);
            if (ph == 4) rows_sel = 2048;
            write_reg(cfrc_pkg::REG_COLS, cfrc_pkg::DIM_W'(cols_sel));
            write_reg(cfrc_pkg::REG_ROWS, cfrc_pkg::DIM_W'(rows_sel));
            if (ph == 1) rx_hold_go = 1'b1;
            n_items = 130;
            for (int k = 0; k < n_items; k++) begin
                if (ph == 2 && k == n_items / 2) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    while (centroid_q.size() != 0) @(negedge i_clk);
                end
                send_random((k == 0 && $urandom_range(1)) || $urandom_range(99) < 2,
                            $urandom_range(20, 80));
            end
            settle();
        end

        // widest image, single row: every pixel reports
        tx_idle_pct = 0;
        rx_stall_pct = 20;
        write_reg(cfrc_pkg::REG_COLS, 12'hFFF);
        write_reg(cfrc_pkg::REG_ROWS, 12'd1);
        send_random(1'b1, 50);
        repeat (200) send_random(1'b0, 50);
        settle();

        // tallest image, single column: long runs
        write_reg(cfrc_pkg::REG_COLS, 12'd1);
        write_reg(cfrc_pkg::REG_ROWS, 12'hFFF);
        send_random(1'b1, 100);
        repeat (200) send_random(1'b0, 99);
        settle();

        if (err_cnt == 0) begin
            $display("column_first_run_centroid_top_tb: done, clean");
        end else begin
            $display("column_first_run_centroid_top_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: column_first_run_centroid_top.f
sv/cfrc_pkg.sv
sv/cfrc_ctrl.sv
sv/cfrc_dp.sv
sv/column_first_run_centroid_top.sv
sim/column_first_run_centroid_top_tb.sv
